### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Immediate-next and same-cycle implication checks, clocked and held off in
// reset, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define AFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define AFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/afs_pkg.sv
// ----------------------------------------------------------------------------
// afs_pkg
// Shared widths, codes, types and sequencer states of the animation frame
// sequencer.
// ----------------------------------------------------------------------------
package afs_pkg;

  // Frame store limit, further clamped to the reach of the frame index
  localparam int MAX_FRAMES  = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int LIMIT_INT   = (MAX_FRAMES < (1 << IDX_W)) ? MAX_FRAMES : (1 << IDX_W);
  localparam logic [CNT_W-1:0] FRAME_LIMIT = CNT_W'(LIMIT_INT);

  // Field widths
  localparam int MS_W    = 16;
  localparam int ACC_W   = 17;
  localparam int SUM_W   = 18;
  localparam int RND_W   = 32;
  localparam int PROD_W  = CNT_W + MS_W;

  // Shared divider: 32-bit dividend, 17-bit divisor, one quotient bit a cycle
  localparam int DIV_N_W   = 32;
  localparam int DIV_D_W   = 17;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_DUR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd4;

  // Register reset values
  localparam logic [MS_W-1:0] RST_FRAME_DUR = 16'd50;
  localparam logic [MS_W-1:0] RST_IDLE_MIN  = 16'd1000;
  localparam logic [MS_W-1:0] RST_IDLE_MAX  = 16'd1000;

  // Loop modes
  localparam logic [1:0] LM_BLINK = 2'd0;
  localparam logic [1:0] LM_LOOP  = 2'd1;
  localparam logic [1:0] LM_IMAGE = 2'd2;

  // Event codes
  localparam logic [1:0] EV_TICK    = 2'd0;
  localparam logic [1:0] EV_RESTART = 2'd1;
  localparam logic [1:0] EV_SET     = 2'd2;

  // Decoded configuration
  typedef struct packed {
    logic [1:0]       loop_mode;
    logic [MS_W-1:0]  dur;
    logic [MS_W-1:0]  idle_min;
    logic [MS_W-1:0]  idle_max;
    logic [CNT_W-1:0] n;
  } cfg_t;

  // Divider request and response
  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_N_W-1:0] quot;
    logic [DIV_D_W-1:0] rem;
  } div_rsp_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOOP_DIV,
    ST_LOOP_MOD,
    ST_BLINK_DIV,
    ST_BLINK_MUL,
    ST_BLINK_END,
    ST_DRAW,
    ST_DRAW_DIV,
    ST_FINISH
  } state_t;

endpackage

### sv/animation_frame_sequencer.sv
// ----------------------------------------------------------------------------
// animation_frame_sequencer
// Frame sequencer for a display animation: image, loop and idle-then-blink
// behaviours driven by tick, restart and set-frame events.
// ----------------------------------------------------------------------------
// One item is taken at a time and yields one result item with the state after
// it. Set-frame, unused events, image ticks, ticks with fewer than two frames,
// idle blink ticks and a restart with a fixed idle time need no divider pass.
// Frame steps, the wrap and the random idle draw all go through one shared
// restoring divider, at most twice per item: a loop tick with no whole frame
// elapsed, a blink-playing tick that stays in the blink and a restart that
// draws a random idle time take one pass, a loop tick that steps two, and a
// tick that ends the blink one with a fixed or two with a random idle draw.
// While a result waits in the output register the next item is already taken
// in; it finishes and holds until that result has gone.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module animation_frame_sequencer import afs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_mode,
  input  logic [MS_W-1:0]      in_delta_ms,
  input  logic [IDX_W-1:0]     in_frame_request,
  input  logic [RND_W-1:0]     in_random_word,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     out_frame_index,
  output logic                 out_playing,
  output logic [MS_W-1:0]      out_idle_left_ms,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_t state_r, state_nxt;

  // Latched item
  logic [1:0]       mode_r;
  logic [MS_W-1:0]  delta_r;
  logic [IDX_W-1:0] req_r;
  logic [RND_W-1:0] rnd_r;

  // Sequencer state
  logic [IDX_W-1:0] cf_r, cf_nxt;
  logic             playing_r, playing_nxt;
  logic [MS_W-1:0]  idle_r, idle_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_frame_r;
  logic             out_playing_r;
  logic [MS_W-1:0]  out_idle_r;
  logic             load_out;

  // Datapath helpers
  logic [SUM_W-1:0]  acc_sum;
  logic              cf_lt_n;
  logic [CNT_W-1:0]  needed;
  logic [SUM_W-1:0]  steps;
  logic [DIV_D_W-1:0] span;
  logic              draw_fixed;
  logic [CNT_W:0]    loop_sum;
  logic [CNT_W:0]    loop_fold;
  logic              loop_wrap;
  logic [PROD_W:0]   blink_left;
  logic [ACC_W-1:0]  blink_acc;

  afs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  afs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall = (state_r != ST_IDLE);

  // Capture the item on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mode_r  <= in_mode;
      delta_r <= in_delta_ms;
      req_r   <= in_frame_request;
      rnd_r   <= in_random_word;
    end
  end

  // Shared helper terms
  always_comb begin
    acc_sum    = {1'b0, acc_r} + {2'b0, delta_r};
    cf_lt_n    = ({1'b0, cf_r} < cfg.n);
    needed     = cf_lt_n ? (cfg.n - {1'b0, cf_r}) : CNT_W'(1);
    steps      = div_rsp.quot[SUM_W-1:0];
    span       = {1'b0, cfg.idle_max} - {1'b0, cfg.idle_min} + DIV_D_W'(1);
    draw_fixed = (cfg.idle_min >= cfg.idle_max);
    loop_sum   = {2'b0, cf_r} + {1'b0, div_rsp.rem[CNT_W-1:0]};
    loop_fold  = loop_sum - {1'b0, cfg.n};
    loop_wrap  = (loop_sum >= {1'b0, cfg.n});
    blink_left = {(PROD_W + 1 - SUM_W)'(0), acc_sum} - {1'b0, prod_r};
    blink_acc  = (blink_left > (PROD_W + 1)'({ACC_W{1'b1}})) ? {ACC_W{1'b1}}
                                                           : blink_left[ACC_W-1:0];
  end

  // Sequencer: next state, state updates and divider requests
  always_comb begin
    state_nxt        = state_r;
    cf_nxt           = cf_r;
    playing_nxt      = playing_r;
    idle_nxt         = idle_r;
    acc_nxt          = acc_r;
    prod_nxt         = prod_r;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {(DIV_N_W - SUM_W)'(0), acc_sum};
    div_req.divisor  = {1'b0, cfg.dur};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end

      ST_DECODE: begin
        state_nxt = ST_FINISH;
        unique case (mode_r)
          EV_TICK: begin
            if (cfg.n > CNT_W'(1)) begin
              unique case (cfg.loop_mode)
                LM_IMAGE: cf_nxt = '0;
                LM_LOOP: begin
                  div_req.start = 1'b1;
                  state_nxt     = ST_LOOP_DIV;
                end
                LM_BLINK: begin
                  if (!playing_r) begin
                    // count down the idle time, start the blink at zero
                    cf_nxt = '0;
                    if (idle_r > delta_r) begin
                      idle_nxt = idle_r - delta_r;
                    end else begin
                      idle_nxt    = '0;
                      playing_nxt = 1'b1;
                      acc_nxt     = '0;
                    end
                  end else begin
                    div_req.start = 1'b1;
                    state_nxt     = ST_BLINK_DIV;
                  end
                end
                default: ;
              endcase
            end
          end
          EV_RESTART: begin
            cf_nxt = '0;
            if (cfg.n != '0) begin
              if (cfg.loop_mode == LM_BLINK) begin
                playing_nxt = 1'b0;
                state_nxt   = ST_DRAW;
              end else begin
                playing_nxt = 1'b1;
              end
            end
          end
          EV_SET: begin
            if ({1'b0, req_r} < cfg.n) cf_nxt = req_r;
          end
          default: ;
        endcase
      end

      // Whole frame durations elapsed; remainder stays in the accumulator
      ST_LOOP_DIV: begin
        if (div_rsp.done) begin
          acc_nxt = div_rsp.rem[ACC_W-1:0];
          if (steps == '0) begin
            state_nxt = ST_FINISH;
          end else begin
            // a frame beyond the count spends one step going to frame 0
            div_req.start    = 1'b1;
            div_req.dividend = {(DIV_N_W - SUM_W)'(0),
                                steps - {(SUM_W - 1)'(0), !cf_lt_n}};
            div_req.divisor  = {(DIV_D_W - CNT_W)'(0), cfg.n};
            cf_nxt           = cf_lt_n ? cf_r : '0;
            state_nxt        = ST_LOOP_MOD;
          end
        end
      end

      // Add the step count modulo the frame count, fold once
      ST_LOOP_MOD: begin
        if (div_rsp.done) begin
          cf_nxt    = loop_wrap ? loop_fold[IDX_W-1:0] : loop_sum[IDX_W-1:0];
          state_nxt = ST_FINISH;
        end
      end

      // Advance the blink, or end it when the last frame is passed
      ST_BLINK_DIV: begin
        if (div_rsp.done) begin
          if (steps >= {(SUM_W - CNT_W)'(0), needed}) begin
            state_nxt = ST_BLINK_MUL;
          end else begin
            acc_nxt   = div_rsp.rem[ACC_W-1:0];
            cf_nxt    = cf_r + steps[IDX_W-1:0];
            state_nxt = ST_FINISH;
          end
        end
      end

      ST_BLINK_MUL: begin
        prod_nxt  = {(PROD_W - CNT_W)'(0), needed} * {(PROD_W - MS_W)'(0), cfg.dur};
        state_nxt = ST_BLINK_END;
      end

      ST_BLINK_END: begin
        acc_nxt     = blink_acc;
        cf_nxt      = '0;
        playing_nxt = 1'b0;
        state_nxt   = ST_DRAW;
      end

      // Draw a new idle time from the random word
      ST_DRAW: begin
        if (draw_fixed) begin
          idle_nxt  = cfg.idle_min;
          state_nxt = ST_FINISH;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = rnd_r;
          div_req.divisor  = span;
          state_nxt        = ST_DRAW_DIV;
        end
      end

      ST_DRAW_DIV: begin
        if (div_rsp.done) begin
          idle_nxt  = cfg.idle_min + div_rsp.rem[MS_W-1:0];
          state_nxt = ST_FINISH;
        end
      end

      // Hold until the output register is free
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on load, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cf_r        <= '0;
      playing_r   <= 1'b0;
      idle_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cf_r        <= cf_nxt;
      playing_r   <= playing_nxt;
      idle_r      <= idle_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (load_out) begin
      out_frame_r   <= cf_r;
      out_playing_r <= playing_r;
      out_idle_r    <= idle_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_index  = out_frame_r;
  assign out_playing      = out_playing_r;
  assign out_idle_left_ms = out_idle_r;

  // Checks
  `AFS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "item accepted but sequencer not busy")
  `AFS_ASSERT_NOW(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy, "divider started while busy")
  `AFS_ASSERT_NOW(a_div_done_waited, clk, rst_n, div_rsp.done, state_r == ST_LOOP_DIV || state_r == ST_LOOP_MOD || state_r == ST_BLINK_DIV || state_r == ST_DRAW_DIV, "divider result with no state waiting")
  `AFS_ASSERT_NEXT(a_result_loaded, clk, rst_n, load_out, out_valid && out_frame_index == $past(cf_r) && out_idle_left_ms == $past(idle_r), "result register not loaded from state")

endmodule

### sv/afs_cfg_regs.sv
// ----------------------------------------------------------------------------
// afs_cfg_regs
// Configuration registers with the frame count clamp and the zero-duration
// guard applied on the way out.
// ----------------------------------------------------------------------------
module afs_cfg_regs import afs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  logic [1:0]       loop_mode_r;
  logic [MS_W-1:0]  dur_r;
  logic [MS_W-1:0]  idle_min_r;
  logic [MS_W-1:0]  idle_max_r;
  logic [CNT_W-1:0] fcount_r;

  // Always able to take a write
  assign cfg_ready = 1'b1;

  // Write one register per handshake; unknown indices are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_mode_r <= LM_BLINK;
      dur_r       <= RST_FRAME_DUR;
      idle_min_r  <= RST_IDLE_MIN;
      idle_max_r  <= RST_IDLE_MAX;
      fcount_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOOP_MODE:   loop_mode_r <= cfg_data[1:0];
        REG_FRAME_DUR:   dur_r       <= cfg_data;
        REG_IDLE_MIN:    idle_min_r  <= cfg_data;
        REG_IDLE_MAX:    idle_max_r  <= cfg_data;
        REG_FRAME_COUNT: fcount_r    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame count and treat a zero duration as one millisecond
  always_comb begin
    cfg.loop_mode = loop_mode_r;
    cfg.dur       = (dur_r == '0) ? MS_W'(1) : dur_r;
    cfg.idle_min  = idle_min_r;
    cfg.idle_max  = idle_max_r;
    cfg.n         = (fcount_r > FRAME_LIMIT) ? FRAME_LIMIT : fcount_r;
  end

endmodule

### sv/afs_div.sv
// ----------------------------------------------------------------------------
// afs_div
// Shared restoring divider: one quotient bit per cycle, quotient and
// remainder held after the done pulse until the next start.
// ----------------------------------------------------------------------------
module afs_div import afs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_N_W-1:0]   quot_r, quot_nxt;
  logic [DIV_D_W-1:0]   dsr_r, dsr_nxt;

  logic [DIV_D_W:0]     shifted;
  logic [DIV_D_W:0]     trial;
  logic                 fits;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem_r, quot_r[DIV_N_W-1]};
    trial   = shifted - {1'b0, dsr_r};
    fits    = (shifted >= {1'b0, dsr_r});
  end

  // Load on start, then shift one bit a cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quot_nxt = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
      quot_nxt = {quot_r[DIV_N_W-2:0], fits};
      cnt_nxt  = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the animation frame sequencer. A directed table
// walks the event kinds through the blink, loop, image and unused modes,
// and the random part then sweeps register settings with runs of events.
// A local model of the sequencer state predicts each result item that has no fixed
// expectation, and the results are compared field by field in order while both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import afs_pkg::*;

  localparam logic [1:0]           LM_UNUSED  = 2'd3;
  localparam logic [1:0]           EV_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int ITEMS_PER_PHASE = 434;
  localparam int SETTLE_CYCLES   = 100;
  localparam int REPORT_CAP      = 100;

  typedef struct packed {
    logic [1:0]       mode;
    logic [MS_W-1:0]  delta;
    logic [IDX_W-1:0] req;
    logic [RND_W-1:0] rnd;
  } seq_event_t;

  typedef struct packed {
    logic [IDX_W-1:0] frame;
    logic             playing;
    logic [MS_W-1:0]  idle_left;
  } frame_state_t;

  typedef enum logic {ROW_WRITE, ROW_EVENT} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DAT_W-1:0]   data;
    seq_event_t             ev;
    bit                     typed;
    frame_state_t           want;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_mode;
  logic [MS_W-1:0]      in_delta_ms;
  logic [IDX_W-1:0]     in_frame_request;
  logic [RND_W-1:0]     in_random_word;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [IDX_W-1:0]     out_frame_index;
  logic                 out_playing;
  logic [MS_W-1:0]      out_idle_left_ms;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // Fixed expectation carried alongside a directed item
  bit           typed_on;
  frame_state_t typed_state;

  int tx_idle_pct = 31;
  int rx_idle_pct = 81;
  int err_count   = 0;
  int cycle_count = 0;

  // Model of the sequencer: registers and state
  logic [1:0]       cfg_loop_mode = LM_BLINK;
  logic [MS_W-1:0]  cfg_dur       = RST_FRAME_DUR;
  logic [MS_W-1:0]  cfg_idle_min  = RST_IDLE_MIN;
  logic [MS_W-1:0]  cfg_idle_max  = RST_IDLE_MAX;
  logic [CNT_W-1:0] cfg_frames    = '0;
  logic [IDX_W-1:0] cur_frame     = '0;
  logic             is_playing    = 1'b0;
  logic [MS_W-1:0]  idle_cd       = '0;
  logic [ACC_W-1:0] acc_ms        = '0;

  frame_state_t owed_states [$];

  // Directed stimulus table
  plan_row_t plan [$];

  animation_frame_sequencer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_delta_ms      (in_delta_ms),
    .in_frame_request (in_frame_request),
    .in_random_word   (in_random_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_index  (out_frame_index),
    .out_playing      (out_playing),
    .out_idle_left_ms (out_idle_left_ms),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  task automatic report_mismatch(input string what);
    if (err_count < REPORT_CAP) $display("[cycle %0d] %s", cycle_count, what);
    err_count++;
  endtask

  // Draw a fresh idle time from the random word
  function automatic logic [MS_W-1:0] draw_idle(logic [RND_W-1:0] rnd);
    int unsigned lo, hi;
    lo = cfg_idle_min;
    hi = cfg_idle_max;
    if (lo >= hi) return cfg_idle_min;
    return MS_W'(lo + rnd % (hi - lo + 1));
  endfunction

  // Advance the model by one item and return the state it reports
  function automatic frame_state_t step_sequencer(seq_event_t ev);
    int unsigned n, dur, sum, steps, needed;
    frame_state_t res;
    n   = (cfg_frames > FRAME_LIMIT) ? FRAME_LIMIT : cfg_frames;
    dur = (cfg_dur == 0) ? 1 : cfg_dur;
    case (ev.mode)
      EV_TICK: begin
        if (n > 1) begin
          case (cfg_loop_mode)
            LM_IMAGE: cur_frame = '0;
            LM_LOOP: begin
              sum    = acc_ms + ev.delta;
              steps  = sum / dur;
              acc_ms = ACC_W'(sum - steps * dur);
              if (steps != 0) begin
                // A frame past the count restarts from the first frame
                if (cur_frame >= n) begin
                  cur_frame = '0;
                  steps--;
                end
                cur_frame = IDX_W'((cur_frame + steps % n) % n);
              end
            end
            LM_BLINK: begin
              if (!is_playing) begin
                cur_frame = '0;
                if (idle_cd > ev.delta) begin
                  idle_cd = idle_cd - ev.delta;
                end else begin
                  idle_cd    = '0;
                  is_playing = 1'b1;
                  acc_ms     = '0;
                end
              end else begin
                sum    = acc_ms + ev.delta;
                steps  = sum / dur;
                needed = (cur_frame < n) ? n - cur_frame : 1;
                if (steps >= needed) begin
                  sum        = sum - needed * dur;
                  cur_frame  = '0;
                  is_playing = 1'b0;
                  idle_cd    = draw_idle(ev.rnd);
                end else begin
                  sum       = sum - steps * dur;
                  cur_frame = IDX_W'(cur_frame + steps);
                end
                acc_ms = (sum > 32'h1FFFF) ? 17'h1FFFF : ACC_W'(sum);
              end
            end
            default: ;
          endcase
        end
      end
      EV_RESTART: begin
        cur_frame = '0;
        if (n > 0) begin
          if (cfg_loop_mode == LM_BLINK) begin
            is_playing = 1'b0;
            idle_cd    = draw_idle(ev.rnd);
          end else begin
            is_playing = 1'b1;
          end
        end
      end
      EV_SET: if (ev.req < n) cur_frame = ev.req;
      default: ;
    endcase
    res.frame     = cur_frame;
    res.playing   = is_playing;
    res.idle_left = idle_cd;
    return res;
  endfunction

  // Check results, predict accepted items and track register writes
  always @(posedge clk) begin : monitor
    frame_state_t want;
    seq_event_t   ev;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (owed_states.size() == 0) begin
          report_mismatch("result item with nothing owed");
        end else begin
          want = owed_states.pop_front();
          if (out_frame_index !== want.frame)
            report_mismatch($sformatf("frame_index got %0d want %0d",
                                      out_frame_index, want.frame));
          if (out_playing !== want.playing)
            report_mismatch($sformatf("playing got %0d want %0d",
                                      out_playing, want.playing));
          if (out_idle_left_ms !== want.idle_left)
            report_mismatch($sformatf("idle_left_ms got %0d want %0d",
                                      out_idle_left_ms, want.idle_left));
        end
      end
      if (in_valid && !in_stall) begin
        ev   = '{in_mode, in_delta_ms, in_frame_request, in_random_word};
        want = step_sequencer(ev);
        owed_states.insert(owed_states.size(), typed_on ? typed_state : want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOOP_MODE:   cfg_loop_mode = cfg_data[1:0];
          REG_FRAME_DUR:   cfg_dur       = cfg_data;
          REG_IDLE_MIN:    cfg_idle_min  = cfg_data;
          REG_IDLE_MAX:    cfg_idle_max  = cfg_data;
          REG_FRAME_COUNT: cfg_frames    = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Hold the sender until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Offer one item after a random gap and hold it until taken
  task automatic send_event(input seq_event_t ev, input bit typed,
                            input frame_state_t fixed);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= ev.mode;
    in_delta_ms      <= ev.delta;
    in_frame_request <= ev.req;
    in_random_word   <= ev.rnd;
    typed_on         <= typed;
    typed_state      <= fixed;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic plan_row_t write_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DAT_W-1:0] data);
    plan_row_t r;
    r       = '{kind: ROW_WRITE, default: '0};
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.data  = data;
    return r;
  endfunction

  function automatic plan_row_t event_row(logic [1:0] mode, logic [MS_W-1:0] delta,
                                          logic [IDX_W-1:0] req, logic [RND_W-1:0] rnd,
                                          bit typed, logic [IDX_W-1:0] frame,
                                          logic playing, logic [MS_W-1:0] idle);
    plan_row_t r;
    r       = '{kind: ROW_EVENT, default: '0};
    r.kind  = ROW_EVENT;
    r.ev    = '{mode, delta, req, rnd};
    r.typed = typed;
    r.want  = '{frame, playing, idle};
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void queue_row(plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  initial begin
    seq_event_t   ev;
    frame_state_t none;
    int           done_items, seg_len, pick, seg_n, seg_dur, span;
    logic [1:0]       lm_pick;
    logic [CFG_DAT_W-1:0] lm_data, dur_data, min_data, max_data, fc_data;

    none             = '0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_mode          <= EV_TICK;
    in_delta_ms      <= '0;
    in_frame_request <= '0;
    in_random_word   <= '0;
    typed_on         <= 1'b0;
    typed_state      <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= REG_LOOP_MODE;
    cfg_data         <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nothing loaded: every event leaves the reset state
    queue_row(event_row(EV_TICK,    16'hFFFF, 6'd0,  32'd0, 1, 6'd0, 1'b0, 16'd0));
    queue_row(event_row(EV_RESTART, 16'd0,    6'd0,  32'd0, 1, 6'd0, 1'b0, 16'd0));
    queue_row(event_row(EV_SET,     16'd0,    6'd0,  32'd0, 1, 6'd0, 1'b0, 16'd0));
    queue_row(event_row(EV_UNUSED,  16'd7,    6'd9,  32'd1, 1, 6'd0, 1'b0, 16'd0));
    // Blink with four frames and a fixed idle time
    queue_row(write_row(REG_FRAME_COUNT, 16'd4));
    queue_row(event_row(EV_SET,     16'd0,    6'd3,  32'd0, 1, 6'd3, 1'b0, 16'd0));
    queue_row(event_row(EV_SET,     16'd0,    6'd63, 32'd0, 1, 6'd3, 1'b0, 16'd0));
    queue_row(event_row(EV_RESTART, 16'd0,    6'd0,  32'd77, 1, 6'd0, 1'b0, 16'd1000));
    queue_row(event_row(EV_TICK,    16'd999,  6'd0,  32'd0, 1, 6'd0, 1'b0, 16'd1));
    queue_row(event_row(EV_TICK,    16'd1,    6'd0,  32'd0, 1, 6'd0, 1'b1, 16'd0));
    queue_row(event_row(EV_TICK,    16'd100,  6'd0,  32'd0, 1, 6'd2, 1'b1, 16'd0));
    queue_row(event_row(EV_TICK,    16'd120,  6'd0,  32'd0, 1, 6'd0, 1'b0, 16'd1000));
    // Widest idle range and its extremes
    queue_row(write_row(REG_IDLE_MAX, 16'hFFFF));
    queue_row(write_row(REG_IDLE_MIN, 16'd0));
    queue_row(event_row(EV_RESTART, 16'd0,    6'd0,  32'hFFFF_FFFF, 1,
                        6'd0, 1'b0, 16'hFFFF));
    queue_row(event_row(EV_TICK,    16'hFFFF, 6'd0,  32'd0, 1, 6'd0, 1'b1, 16'd0));
    queue_row(event_row(EV_TICK,    16'hFFFF, 6'd0,  32'd0, 1, 6'd0, 1'b0, 16'd0));
    queue_row(event_row(EV_TICK,    16'd0,    6'd0,  32'd0, 1, 6'd0, 1'b1, 16'd0));
    // Zero duration counts as one millisecond
    queue_row(write_row(REG_FRAME_DUR, 16'd0));
    queue_row(event_row(EV_TICK,    16'd2,    6'd0,  32'd0, 1, 6'd2, 1'b1, 16'd0));
    // Count lowered below the shown frame ends the blink
    queue_row(write_row(REG_FRAME_COUNT, 16'd2));
    queue_row(event_row(EV_TICK,    16'd1,    6'd0,  32'd5, 1, 6'd0, 1'b0, 16'd5));
    // Loop with an oversized count, clamped to the full frame range
    queue_row(write_row(REG_LOOP_MODE, 16'(LM_LOOP)));
    queue_row(write_row(REG_FRAME_DUR, 16'hFFFF));
    queue_row(write_row(REG_FRAME_COUNT, 16'hFF7F));
    queue_row(event_row(EV_SET,     16'd0,    6'd63, 32'd0, 1, 6'd63, 1'b0, 16'd5));
    queue_row(event_row(EV_TICK,    16'hFFFF, 6'd0,  32'd0, 0, 6'd0, 1'b0, 16'd0));
    queue_row(event_row(EV_RESTART, 16'd0,    6'd0,  32'd0, 1, 6'd0, 1'b1, 16'd5));
    // Loop advance from a frame beyond the count
    queue_row(write_row(REG_FRAME_DUR, 16'd1));
    queue_row(write_row(REG_FRAME_COUNT, 16'd3));
    queue_row(event_row(EV_SET,     16'd0,    6'd2,  32'd0, 1, 6'd2, 1'b1, 16'd5));
    queue_row(write_row(REG_FRAME_COUNT, 16'd2));
    queue_row(event_row(EV_TICK,    16'd2,    6'd0,  32'd0, 0, 6'd0, 1'b0, 16'd0));
    // Static image, then the unused mode code
    queue_row(write_row(REG_LOOP_MODE, 16'(LM_IMAGE)));
    queue_row(event_row(EV_TICK,    16'd7,    6'd0,  32'd0, 1, 6'd0, 1'b1, 16'd5));
    queue_row(event_row(EV_SET,     16'd0,    6'd1,  32'd0, 1, 6'd1, 1'b1, 16'd5));
    queue_row(write_row(REG_LOOP_MODE, 16'(LM_UNUSED)));
    queue_row(event_row(EV_TICK,    16'd100,  6'd0,  32'd0, 1, 6'd1, 1'b1, 16'd5));
    queue_row(event_row(EV_RESTART, 16'd0,    6'd0,  32'd0, 1, 6'd0, 1'b1, 16'd5));
    queue_row(write_row(REG_UNUSED, 16'hFFFF));
    queue_row(event_row(EV_SET,     16'd0,    6'd1,  32'd0, 1, 6'd1, 1'b1, 16'd5));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_register(plan[i].idx, plan[i].data);
      else send_event(plan[i].ev, plan[i].typed, plan[i].want);
    end

    // Random part in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 31; rx_idle_pct = 81; end
        1: begin tx_idle_pct = 81; rx_idle_pct = 31; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        // Pick a register setting, extremes now and then
        pick = $urandom_range(99);
        lm_pick = (pick < 45) ? LM_BLINK : (pick < 75) ? LM_LOOP :
                  (pick < 90) ? LM_IMAGE : LM_UNUSED;
        lm_data = 16'(lm_pick);
        if ($urandom_range(9) == 0) lm_data[15:2] = 14'($urandom);
        pick = $urandom_range(99);
        dur_data = (pick < 60) ? 16'($urandom_range(1, 40)) :
                   (pick < 75) ? 16'd0 :
                   (pick < 85) ? 16'($urandom_range(41, 1000)) :
                   (pick < 93) ? 16'hFFFF : 16'($urandom);
        pick = $urandom_range(99);
        min_data = (pick < 70) ? 16'($urandom_range(0, 200)) :
                   (pick < 80) ? 16'd0 : (pick < 90) ? 16'hFFFF : 16'($urandom);
        pick = $urandom_range(99);
        max_data = (pick < 60) ? 16'($urandom_range(0, 400)) :
                   (pick < 75) ? min_data : (pick < 85) ? 16'hFFFF : 16'($urandom);
        pick = $urandom_range(99);
        fc_data = (pick < 70) ? 16'($urandom_range(2, 8)) :
                  (pick < 80) ? 16'($urandom_range(9, 64)) :
                  (pick < 88) ? 16'($urandom_range(0, 1)) :
                  (pick < 94) ? 16'd64 : 16'($urandom_range(65, 127));
        if ($urandom_range(9) == 0) fc_data[15:7] = 9'($urandom);
        write_register(REG_LOOP_MODE, lm_data);
        write_register(REG_FRAME_DUR, dur_data);
        write_register(REG_IDLE_MIN, min_data);
        write_register(REG_IDLE_MAX, max_data);
        write_register(REG_FRAME_COUNT, fc_data);

        seg_n   = (fc_data[6:0] > 64) ? 64 : fc_data[6:0];
        seg_dur = (dur_data == 0) ? 1 : dur_data;
        span    = (3 * seg_dur > 65535) ? 65535 : 3 * seg_dur;
        seg_len = $urandom_range(20, 60);
        for (int k = 0; k < seg_len; k++) begin
          ev.delta = 16'($urandom);
          ev.req   = 6'($urandom);
          ev.rnd   = $urandom;
          pick     = $urandom_range(99);
          // Open most runs with a restart so blink runs start from idle
          if (k == 0 && $urandom_range(9) < 7) pick = 75;
          if (pick < 72) begin
            ev.mode = EV_TICK;
            case ($urandom_range(9))
              0: ev.delta = '0;
              1: ;
              default: ev.delta = 16'($urandom_range(0, span));
            endcase
          end else if (pick < 82) begin
            ev.mode = EV_RESTART;
          end else if (pick < 96) begin
            ev.mode = EV_SET;
            if ($urandom_range(9) < 6)
              ev.req = 6'($urandom_range(0, (seg_n > 0) ? seg_n - 1 : 0));
          end else begin
            ev.mode = EV_UNUSED;
          end
          send_event(ev, 1'b0, none);
        end
        done_items += seg_len;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_states.size() != 0)
      report_mismatch($sformatf("%0d result items never came", owed_states.size()));
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
